// ===== sv/wpk_pkg.sv =====
// ----------------------------------------------------------------------------
// wpk_pkg
// Shared types and constants for the window packetizer.
// ----------------------------------------------------------------------------
package wpk_pkg;

    localparam int WORDS_PER_PACKET_DEFAULT = 50;

    // Packet position and padding counts; covers packet sizes up to 63 words.
    localparam int PPOS_W = 6;

    localparam logic [7:0] HDR_FIRST_MARK = 8'hAA;
    localparam logic [7:0] HDR_LATER_MARK = 8'hBB;

    localparam logic [2:0] BYTES_FULL = 3'd4;
    localparam logic [2:0] BYTES_ONE  = 3'd1;

    // One accepted word and everything needed to emit its chunks.
    typedef struct packed {
        logic [31:0]       word;
        logic [15:0]       len;
        logic [7:0]        peaks;
        logic              hdr_first;
        logic              hdr_later;
        logic [PPOS_W-1:0] pad_total;
        logic              pend;
        logic              wend;
    } job_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_HDR,
        PH_LEN_HI,
        PH_WORD,
        PH_PAD
    } phase_t;

endpackage

// ===== sv/wpk_frontend.sv =====
// ----------------------------------------------------------------------------
// wpk_frontend
// Window/packet position tracking; turns each request into a chunk job.
// ----------------------------------------------------------------------------
module wpk_frontend #(
    parameter int WORDS_PER_PACKET = wpk_pkg::WORDS_PER_PACKET_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_sample_word,
    input  logic [13:0]        s_total_words,
    input  logic [7:0]         s_peak_count,
    input  logic               job_pop,
    output logic               job_valid,
    output wpk_pkg::job_t      job
);

    localparam logic [wpk_pkg::PPOS_W-1:0] WPP = wpk_pkg::PPOS_W'(WORDS_PER_PACKET);

    logic [13:0]                 window_position_reg, window_position_next;
    logic [wpk_pkg::PPOS_W-1:0]  packet_position_reg, packet_position_next;
    logic                        in_first_packet_reg, in_first_packet_next;
    logic                        job_valid_reg, job_valid_next;
    wpk_pkg::job_t               job_reg, job_next;

    logic                        accept;
    logic [wpk_pkg::PPOS_W-1:0]  pp1;
    logic [14:0]                 wp1;
    logic                        wend;
    logic                        pend;
    logic                        pad;

    assign s_ready = !job_valid_reg || job_pop;
    assign accept  = s_valid && s_ready;

    assign pp1  = packet_position_reg + 1'b1;
    assign wp1  = {1'b0, window_position_reg} + 15'd1;
    assign wend = wp1 >= {1'b0, s_total_words};
    assign pend = pp1 >= WPP;
    assign pad  = wend && !pend && in_first_packet_reg;

    always_comb begin
        job_next.word      = s_sample_word;
        job_next.len       = {s_total_words, 2'b00};
        job_next.peaks     = s_peak_count;
        job_next.hdr_first = (packet_position_reg == '0) && in_first_packet_reg;
        job_next.hdr_later = (packet_position_reg == '0) && !in_first_packet_reg;
        job_next.pad_total = pad ? (WPP - pp1) : '0;
        job_next.pend      = !pad && (wend || pend);
        job_next.wend      = !pad && wend;
    end

    always_comb begin
        window_position_next = window_position_reg;
        packet_position_next = packet_position_reg;
        in_first_packet_next = in_first_packet_reg;
        job_valid_next       = job_valid_reg;
        if (accept) begin
            job_valid_next = 1'b1;
            if (wend) begin
                window_position_next = '0;
                packet_position_next = '0;
                in_first_packet_next = 1'b1;
            end else begin
                window_position_next = wp1[13:0];
                if (pend) begin
                    packet_position_next = '0;
                    in_first_packet_next = 1'b0;
                end else begin
                    packet_position_next = pp1;
                end
            end
        end else if (job_pop) begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_position_reg <= '0;
            packet_position_reg <= '0;
            in_first_packet_reg <= 1'b1;
            job_valid_reg       <= 1'b0;
        end else begin
            window_position_reg <= window_position_next;
            packet_position_reg <= packet_position_next;
            in_first_packet_reg <= in_first_packet_next;
            job_valid_reg       <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    a_ppos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        packet_position_reg < WPP)
        else $error("packet position out of range");

    a_first_implies_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (window_position_reg == '0) |-> (packet_position_reg == '0) && in_first_packet_reg)
        else $error("window start not at first packet start");

    a_pop_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> job_valid_reg)
        else $error("job popped while empty");

endmodule

// ===== sv/wpk_emitter.sv =====
// ----------------------------------------------------------------------------
// wpk_emitter
// Walks one job through header, word and padding chunks into the output
// register, one chunk per cycle while the output register is free or taken.
// ----------------------------------------------------------------------------
module wpk_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    input  wpk_pkg::job_t      job,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_chunk,
    output logic [2:0]         m_byte_count,
    output logic               m_packet_end,
    output logic               m_window_end
);

    wpk_pkg::phase_t             phase_reg, phase_next, phase_cur;
    logic [wpk_pkg::PPOS_W-1:0]  pad_cnt_reg, pad_cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic [31:0]                 chunk_reg, chunk_next;
    logic [2:0]                  count_reg, count_next;
    logic                        pend_reg, pend_next;
    logic                        wend_reg, wend_next;

    logic                        load;
    logic                        fire;
    logic                        last;
    logic                        pad_last;

    assign load     = !m_valid_reg || m_ready;
    assign fire     = job_valid && load;
    assign pad_last = (pad_cnt_reg + 1'b1) == job.pad_total;
    assign job_pop  = fire && last;

    always_comb begin
        phase_cur = phase_reg;
        if (phase_reg == wpk_pkg::PH_START) begin
            phase_cur = (job.hdr_first || job.hdr_later) ? wpk_pkg::PH_HDR
                                                         : wpk_pkg::PH_WORD;
        end
    end

    // chunk contents for the current phase
    always_comb begin
        chunk_next = '0;
        count_next = wpk_pkg::BYTES_FULL;
        pend_next  = 1'b0;
        wend_next  = 1'b0;
        last       = 1'b0;
        case (phase_cur)
            wpk_pkg::PH_HDR: begin
                if (job.hdr_first) begin
                    chunk_next = {job.len[7:0], job.peaks,
                                  wpk_pkg::HDR_FIRST_MARK, wpk_pkg::HDR_FIRST_MARK};
                end else begin
                    chunk_next = {job.len[15:8], job.len[7:0],
                                  wpk_pkg::HDR_LATER_MARK, wpk_pkg::HDR_LATER_MARK};
                end
            end
            wpk_pkg::PH_LEN_HI: begin
                chunk_next = {24'd0, job.len[15:8]};
                count_next = wpk_pkg::BYTES_ONE;
            end
            wpk_pkg::PH_WORD: begin
                chunk_next = job.word;
                pend_next  = job.pend;
                wend_next  = job.wend;
                last       = job.pad_total == '0;
            end
            wpk_pkg::PH_PAD: begin
                pend_next = pad_last;
                wend_next = pad_last;
                last      = pad_last;
            end
            default: begin
                chunk_next = '0;
            end
        endcase
    end

    // phase sequencing
    always_comb begin
        phase_next   = phase_reg;
        pad_cnt_next = pad_cnt_reg;
        if (fire) begin
            case (phase_cur)
                wpk_pkg::PH_HDR: begin
                    phase_next = job.hdr_first ? wpk_pkg::PH_LEN_HI : wpk_pkg::PH_WORD;
                end
                wpk_pkg::PH_LEN_HI: begin
                    phase_next = wpk_pkg::PH_WORD;
                end
                wpk_pkg::PH_WORD: begin
                    phase_next   = last ? wpk_pkg::PH_START : wpk_pkg::PH_PAD;
                    pad_cnt_next = '0;
                end
                wpk_pkg::PH_PAD: begin
                    phase_next   = pad_last ? wpk_pkg::PH_START : wpk_pkg::PH_PAD;
                    pad_cnt_next = pad_cnt_reg + 1'b1;
                end
                default: begin
                    phase_next = wpk_pkg::PH_START;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= wpk_pkg::PH_START;
            pad_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pad_cnt_reg <= pad_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            chunk_reg <= chunk_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            wend_reg  <= wend_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_chunk      = chunk_reg;
    assign m_byte_count = count_reg;
    assign m_packet_end = pend_reg;
    assign m_window_end = wend_reg;

    a_wend_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && wend_reg |-> pend_reg)
        else $error("window end without packet end");

    a_short_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (count_reg == wpk_pkg::BYTES_ONE) |-> (chunk_reg[31:8] == '0))
        else $error("short chunk has stray upper bytes");

    a_pad_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wpk_pkg::PH_PAD) |-> (pad_cnt_reg < job.pad_total))
        else $error("padding overran");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |=> (phase_reg == wpk_pkg::PH_START))
        else $error("sequencer not rearmed after job");

endmodule

// ===== sv/window_packetizer_unit.sv =====
// ----------------------------------------------------------------------------
// window_packetizer_unit
// Packs windows of 32-bit sample words into link packets.
// ----------------------------------------------------------------------------
// Input channel (s_*): one sample word per request with the window's word
// count and peak count. Output channel (m_*): little-endian chunks of 1 or 4
// bytes, each with a byte count and packet-end / window-end marks.
// Each word yields its own 4-byte chunk, preceded by a 4+1 byte header at the
// start of the window's first packet or a 4-byte header at later packets. A
// window that ends inside its first packet is padded with zero words to the
// full packet length.
// The first chunk of a word passes through the job register and then the
// output register. Throughput: one chunk per cycle from the output sequencer
// while the receiver takes chunks; a word has 1 to 3 chunks, or up to
// WORDS_PER_PACKET + 2 with padding. The next word is accepted while the
// last chunk of the current one is being loaded into the output register.
// Reset: synchronous, active low; clears window and packet positions and
// drops any pending chunks. A stalled receiver holds the output register and
// backs up into s_ready once the job register is occupied.
// ----------------------------------------------------------------------------
module window_packetizer_unit #(
    parameter int WORDS_PER_PACKET = wpk_pkg::WORDS_PER_PACKET_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample_word,
    input  logic [13:0] s_total_words,
    input  logic [7:0]  s_peak_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_chunk,
    output logic [2:0]  m_byte_count,
    output logic        m_packet_end,
    output logic        m_window_end
);

    logic          job_valid;
    logic          job_pop;
    wpk_pkg::job_t job;

    wpk_frontend #(
        .WORDS_PER_PACKET (WORDS_PER_PACKET)
    ) u_frontend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_word (s_sample_word),
        .s_total_words (s_total_words),
        .s_peak_count  (s_peak_count),
        .job_pop       (job_pop),
        .job_valid     (job_valid),
        .job           (job)
    );

    wpk_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_chunk      (m_chunk),
        .m_byte_count (m_byte_count),
        .m_packet_end (m_packet_end),
        .m_window_end (m_window_end)
    );

endmodule
